// ===== sv/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg: shared types, constants and microprogram of the frame allocator
//
// Bitmap geometry, field widths, codes, control and flag structs, and the
// read-only control store that sequences the datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int STORE_FRAMES = 32768;
   localparam int PAGE_BYTES   = 4096;
   localparam int WORD_BITS    = 32;

   localparam int MAP_WORDS  = (STORE_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W     = $clog2(MAP_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int IDX_W      = WIDX_W + BIT_W;
   localparam int FRAME_W    = $clog2(STORE_FRAMES + 1);
   localparam int NW_W       = FRAME_W - BIT_W;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   localparam int CFG_W      = 16;
   localparam int CMP_W      = (FRAME_W > CFG_W) ? FRAME_W : CFG_W;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_ADDR_W = 32;
   localparam int ADDR_W     = 27;
   localparam int DATA_W     = 32;
   localparam int REQ_FRAME_W = REQ_ADDR_W - PAGE_SHIFT;
   localparam int OOR_W      = (REQ_FRAME_W > FRAME_W) ? REQ_FRAME_W : FRAME_W;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = CFG_W'(32768);
   localparam logic [CFG_W-1:0] RESERVED_RESET    = '0;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED    = 1'b1;

   localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_NO_FRAME = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_ALLOC,
      COND_FREE,
      COND_INIT,
      COND_LAST,
      COND_STOP,
      COND_HIT,
      COND_OOR,
      COND_BUSY
   } cond_type;

   typedef enum logic {
      ADR_CNT,
      ADR_TGT
   } adr_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_FILL,
      WR_SET,
      WR_CLR
   } wr_sel_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_DONE,
      RSP_GRANT,
      RSP_OOM,
      RSP_RANGE
   } rsp_kind_type;

   typedef enum logic [4:0] {
      P_BOOT,
      P_BOOT_FILL,
      P_IDLE,
      P_DISP_A,
      P_DISP_F,
      P_DISP_I,
      P_INIT_FILL,
      P_EMIT_DONE,
      P_ALLOC_START,
      P_ALLOC_SCAN,
      P_ALLOC_CHK,
      P_GRANT_RD,
      P_GRANT_WR,
      P_EMIT_GRANT,
      P_EMIT_OOM,
      P_FREE_CHK,
      P_FREE_RD,
      P_FREE_WR,
      P_EMIT_RANGE
   } step_type;

   typedef struct packed {
      logic         accept;
      logic         ld_n_zero;
      logic         ld_n_res;
      logic         cnt_clr;
      logic         cnt_inc;
      logic         mem_rd;
      adr_sel_type  adr_sel;
      wr_sel_type   wr_sel;
      logic         eval;
      rsp_kind_type rsp_kind;
      cond_type     cond;
      step_type     tgt_t;
      step_type     tgt_f;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic mode_alloc;
      logic mode_free;
      logic mode_init;
      logic cnt_last;
      logic scan_stop;
      logic hit;
      logic oor;
      logic rsp_busy;
   } flags_type;

   // Limits a configured frame count to the size of the store.
   function automatic logic [FRAME_W-1:0] clip_frames(input logic [CFG_W-1:0] v);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(v);
      if (wide > CMP_W'(STORE_FRAMES)) begin
         wide = CMP_W'(STORE_FRAMES);
      end
      return wide[FRAME_W-1:0];
   endfunction

   // Bits of bitmap word w whose frames lie below n.
   function automatic logic [WORD_BITS-1:0] frames_mask(input logic [WIDX_W-1:0] w,
                                                        input logic [FRAME_W-1:0] n);
      logic [NW_W-1:0]      nw;
      logic [NW_W-1:0]      ww;
      logic [WORD_BITS-1:0] m;
      nw = n[FRAME_W-1:BIT_W];
      ww = NW_W'(w);
      if (ww < nw) begin
         m = '1;
      end else if (ww == nw) begin
         m = ~({WORD_BITS{1'b1}} << n[BIT_W-1:0]);
      end else begin
         m = '0;
      end
      return m;
   endfunction

   function automatic ctrl_type ucode_rom(input step_type step);
      ctrl_type c;
      c = '0;
      c.adr_sel  = ADR_CNT;
      c.wr_sel   = WR_NONE;
      c.rsp_kind = RSP_NONE;
      c.cond     = COND_ALWAYS;
      c.tgt_t    = P_IDLE;
      c.tgt_f    = P_IDLE;
      case (step)
         P_BOOT: begin
            c.ld_n_zero = 1'b1;
            c.cnt_clr   = 1'b1;
            c.tgt_t     = P_BOOT_FILL;
         end
         P_BOOT_FILL: begin
            c.wr_sel  = WR_FILL;
            c.cnt_inc = 1'b1;
            c.cond    = COND_LAST;
            c.tgt_t   = P_IDLE;
            c.tgt_f   = P_BOOT_FILL;
         end
         P_IDLE: begin
            c.accept   = 1'b1;
            c.ld_n_res = 1'b1;
            c.cnt_clr  = 1'b1;
            c.cond     = COND_REQ;
            c.tgt_t    = P_DISP_A;
            c.tgt_f    = P_IDLE;
         end
         P_DISP_A: begin
            c.cond  = COND_ALLOC;
            c.tgt_t = P_ALLOC_START;
            c.tgt_f = P_DISP_F;
         end
         P_DISP_F: begin
            c.cond  = COND_FREE;
            c.tgt_t = P_FREE_CHK;
            c.tgt_f = P_DISP_I;
         end
         P_DISP_I: begin
            c.cond  = COND_INIT;
            c.tgt_t = P_INIT_FILL;
            c.tgt_f = P_EMIT_DONE;
         end
         P_INIT_FILL: begin
            c.wr_sel  = WR_FILL;
            c.cnt_inc = 1'b1;
            c.cond    = COND_LAST;
            c.tgt_t   = P_EMIT_DONE;
            c.tgt_f   = P_INIT_FILL;
         end
         P_EMIT_DONE: begin
            c.rsp_kind = RSP_DONE;
            c.cond     = COND_BUSY;
            c.tgt_t    = P_EMIT_DONE;
            c.tgt_f    = P_IDLE;
         end
         P_ALLOC_START: begin
            c.mem_rd  = 1'b1;
            c.cnt_inc = 1'b1;
            c.tgt_t   = P_ALLOC_SCAN;
         end
         P_ALLOC_SCAN: begin
            c.mem_rd  = 1'b1;
            c.cnt_inc = 1'b1;
            c.eval    = 1'b1;
            c.cond    = COND_STOP;
            c.tgt_t   = P_ALLOC_CHK;
            c.tgt_f   = P_ALLOC_SCAN;
         end
         P_ALLOC_CHK: begin
            c.cond  = COND_HIT;
            c.tgt_t = P_GRANT_RD;
            c.tgt_f = P_EMIT_OOM;
         end
         P_GRANT_RD: begin
            c.mem_rd  = 1'b1;
            c.adr_sel = ADR_TGT;
            c.tgt_t   = P_GRANT_WR;
         end
         P_GRANT_WR: begin
            c.adr_sel = ADR_TGT;
            c.wr_sel  = WR_SET;
            c.tgt_t   = P_EMIT_GRANT;
         end
         P_EMIT_GRANT: begin
            c.rsp_kind = RSP_GRANT;
            c.cond     = COND_BUSY;
            c.tgt_t    = P_EMIT_GRANT;
            c.tgt_f    = P_IDLE;
         end
         P_EMIT_OOM: begin
            c.rsp_kind = RSP_OOM;
            c.cond     = COND_BUSY;
            c.tgt_t    = P_EMIT_OOM;
            c.tgt_f    = P_IDLE;
         end
         P_FREE_CHK: begin
            c.cond  = COND_OOR;
            c.tgt_t = P_EMIT_RANGE;
            c.tgt_f = P_FREE_RD;
         end
         P_FREE_RD: begin
            c.mem_rd  = 1'b1;
            c.adr_sel = ADR_TGT;
            c.tgt_t   = P_FREE_WR;
         end
         P_FREE_WR: begin
            c.adr_sel = ADR_TGT;
            c.wr_sel  = WR_CLR;
            c.tgt_t   = P_EMIT_DONE;
         end
         P_EMIT_RANGE: begin
            c.rsp_kind = RSP_RANGE;
            c.cond     = COND_BUSY;
            c.tgt_t    = P_EMIT_RANGE;
            c.tgt_f    = P_IDLE;
         end
         default: begin
            c.tgt_t = P_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== sv/bfa_sequencer.sv =====
// ----------------------------------------------------------------------------
// bfa_sequencer: step counter and control store
//
// Holds the current step, reads its control word from the control store and
// picks the next step from the word's condition and its two jump targets.
// ----------------------------------------------------------------------------
module bfa_sequencer
   import bfa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   step_type pc_ff;
   step_type pc_in;
   logic     cond_true;

   assign ctrl = ucode_rom(pc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS: cond_true = 1'b1;
         COND_REQ:    cond_true = flags.req_valid;
         COND_ALLOC:  cond_true = flags.mode_alloc;
         COND_FREE:   cond_true = flags.mode_free;
         COND_INIT:   cond_true = flags.mode_init;
         COND_LAST:   cond_true = flags.cnt_last;
         COND_STOP:   cond_true = flags.scan_stop;
         COND_HIT:    cond_true = flags.hit;
         COND_OOR:    cond_true = flags.oor;
         COND_BUSY:   cond_true = flags.rsp_busy;
         default:     cond_true = 1'b1;
      endcase
      pc_in = cond_true ? ctrl.tgt_t : ctrl.tgt_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= P_BOOT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== sv/bfa_datapath.sv =====
// ----------------------------------------------------------------------------
// bfa_datapath: bitmap store, scan logic and response register
//
// Bitmap memory with a registered read port, word counter, first-free search
// over one word, target frame register, settings and the response register.
// ----------------------------------------------------------------------------
module bfa_datapath
   import bfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_type              ctrl,
   output flags_type             flags,
   input  logic                  req_tvalid,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [REQ_ADDR_W-1:0] req_phys_address,
   input  logic                  rsp_tready,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ADDR_W-1:0]     rsp_frame_address,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

   logic [CFG_W-1:0]     frame_count_ff;
   logic [CFG_W-1:0]     reserved_ff;
   logic [FRAME_W-1:0]   n_ff;
   logic [WIDX_W-1:0]    cnt_ff;
   logic [WIDX_W-1:0]    rd_w_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]     tgt_ff;
   logic [IDX_W-1:0]     tgt_in;
   logic [MODE_W-1:0]    mode_ff;
   logic                 oor_ff;
   logic                 hit_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           status_ff;
   status_type           status_in;
   logic [ADDR_W-1:0]    faddr_ff;
   logic [ADDR_W-1:0]    faddr_in;

   logic [FRAME_W-1:0]     lim;
   logic                   fire;
   logic [REQ_FRAME_W-1:0] req_frame;
   logic                   req_oor;
   logic [WIDX_W-1:0]      mem_addr;
   logic [WORD_BITS-1:0]   tgt_onehot;
   logic [WORD_BITS-1:0]   wr_data;
   logic [WORD_BITS-1:0]   free_bits;
   logic [BIT_W-1:0]       found_bit;
   logic                   scan_hit;
   logic                   scan_end;
   logic                   rsp_busy;
   logic                   emit_go;

   assign lim       = clip_frames(frame_count_ff);
   assign fire      = ctrl.accept & req_tvalid;
   assign req_frame = req_phys_address[REQ_ADDR_W-1:PAGE_SHIFT];
   assign req_oor   = OOR_W'(req_frame) >= OOR_W'(lim);
   assign mem_addr  = (ctrl.adr_sel == ADR_TGT) ? tgt_ff[IDX_W-1:BIT_W] : cnt_ff;
   assign tgt_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << tgt_ff[BIT_W-1:0];

   always_comb begin
      case (ctrl.wr_sel)
         WR_FILL: wr_data = frames_mask(cnt_ff, n_ff);
         WR_SET:  wr_data = rd_data_ff | tgt_onehot;
         WR_CLR:  wr_data = rd_data_ff & ~tgt_onehot;
         default: wr_data = rd_data_ff;
      endcase
   end

   // Lowest free frame of the word just read, frames at or past the limit
   // counting as used.
   always_comb begin
      free_bits = ~rd_data_ff & frames_mask(rd_w_ff, lim);
      found_bit = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (free_bits[j]) begin
            found_bit = BIT_W'(j);
         end
      end
      scan_hit = |free_bits;
      scan_end = ((FRAME_W + 1)'({rd_w_ff, {BIT_W{1'b0}}}) + (FRAME_W + 1)'(WORD_BITS))
                 >= (FRAME_W + 1)'(lim);
   end

   assign rsp_busy = rsp_valid_ff & ~rsp_tready;
   assign emit_go  = (ctrl.rsp_kind != RSP_NONE) & ~rsp_busy;

   always_comb begin
      tgt_in = tgt_ff;
      if (fire) begin
         tgt_in = req_frame[IDX_W-1:0];
      end else if (ctrl.eval && scan_hit) begin
         tgt_in = {rd_w_ff, found_bit};
      end
   end

   always_comb begin
      case (ctrl.rsp_kind)
         RSP_GRANT: begin
            status_in = ST_DONE;
            faddr_in  = ADDR_W'(tgt_ff) << PAGE_SHIFT;
         end
         RSP_OOM: begin
            status_in = ST_NO_FRAME;
            faddr_in  = '0;
         end
         RSP_RANGE: begin
            status_in = ST_RANGE;
            faddr_in  = '0;
         end
         default: begin
            status_in = ST_DONE;
            faddr_in  = '0;
         end
      endcase
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_sel != WR_NONE) begin
         map_mem[mem_addr] <= wr_data;
      end
      if (ctrl.mem_rd) begin
         rd_data_ff <= map_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
         reserved_ff    <= RESERVED_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wen && csr_index == CSR_FRAME_COUNT) begin
            frame_count_ff <= csr_wdata;
         end
         if (csr_wen && csr_index == CSR_RESERVED) begin
            reserved_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_n_zero) begin
         n_ff <= '0;
      end else if (ctrl.ld_n_res) begin
         n_ff <= clip_frames(reserved_ff);
      end
      if (ctrl.cnt_clr) begin
         cnt_ff <= '0;
      end else if (ctrl.cnt_inc) begin
         cnt_ff <= cnt_ff + WIDX_W'(1);
      end
      if (ctrl.mem_rd && ctrl.adr_sel == ADR_CNT) begin
         rd_w_ff <= cnt_ff;
      end
      if (fire) begin
         mode_ff <= req_mode;
         oor_ff  <= req_oor;
      end
      if (ctrl.eval) begin
         hit_ff <= scan_hit;
      end
      tgt_ff <= tgt_in;
      if (emit_go) begin
         status_ff <= status_in;
         faddr_ff  <= faddr_in;
      end
   end

   assign flags.req_valid  = req_tvalid;
   assign flags.mode_alloc = mode_ff == MODE_ALLOC;
   assign flags.mode_free  = mode_ff == MODE_FREE;
   assign flags.mode_init  = mode_ff == MODE_INIT;
   assign flags.cnt_last   = cnt_ff == WIDX_W'(MAP_WORDS - 1);
   assign flags.scan_stop  = scan_hit | scan_end;
   assign flags.hit        = hit_ff;
   assign flags.oor        = oor_ff;
   assign flags.rsp_busy   = rsp_busy;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_frame_address = faddr_ff;

   a_grant_sets_free_bit: assert property (@(posedge clock) disable iff (reset)
      (ctrl.wr_sel == WR_SET) |-> ((rd_data_ff & tgt_onehot) == '0))
      else $error("grant marks a frame that is already used");

   a_grant_below_limit: assert property (@(posedge clock) disable iff (reset)
      (emit_go && ctrl.rsp_kind == RSP_GRANT) |-> (hit_ff && FRAME_W'(tgt_ff) < lim))
      else $error("granted frame lies at or past the frame limit");

   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.wr_sel == WR_CLR) |-> (!oor_ff && mode_ff == MODE_FREE))
      else $error("bitmap cleared for an out of range free");

endmodule

// ===== sv/bitmap_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: first-fit page frame allocator over a used bitmap
//
//   channel  direction  transfer contents
//   req      in         tuser: mode; tdata: phys_address
//   rsp      out        tuser: status; tdata: frame_address
//   csr      in         write of frame_count (0) or reserved_frames (1)
//
// One item at a time under a microcoded sequencer. A free clears the frame's
// bit by read and write back, or answers a range status when out of range;
// alloc scans the words in order (up to 1024) until a free frame or the limit,
// sets its bit, or answers no frame; init rewrites every word, one word written
// per cycle; an unused mode answers done. After reset a clearing pass writes
// every word before the first request transfer. A result waiting on rsp holds
// the sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
   import bfa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // [31:0] phys_address
   input  logic [MODE_W-1:0]    req_tuser,   // [1:0] mode
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // [26:0] frame_address, [31:27] zero
   output logic [STATUS_W-1:0]  rsp_tuser,   // [1:0] status
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   ctrl_type          ctrl;
   flags_type         flags;
   logic [ADDR_W-1:0] frame_address;

   bfa_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   bfa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .flags             (flags),
      .req_tvalid        (req_tvalid),
      .req_mode          (req_tuser),
      .req_phys_address  (req_tdata[REQ_ADDR_W-1:0]),
      .rsp_tready        (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_status        (rsp_tuser),
      .rsp_frame_address (frame_address),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   assign req_tready = ctrl.accept;
   assign rsp_tdata  = {{(DATA_W - ADDR_W){1'b0}}, frame_address};

endmodule
